FILE: rtl/core/cfsp_pkg.sv
// Package for the CRC-framed setpoint packet parser: frame geometry, header codes,
// CRC-16/CCITT-FALSE constants and step function, parse phases and payload structs.
// No dependencies.
package cfsp_pkg;

  // Total frame length in bytes, header and CRC trailer included (11 to 64).
  localparam int FRAME_LENGTH = 11;
  localparam int IDX_W        = 6;

  localparam logic [IDX_W-1:0] IDX_PAYLOAD_FIRST = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_PAYLOAD_LAST  = IDX_W'(8);
  localparam logic [IDX_W-1:0] IDX_TRAILER_HIGH  = IDX_W'(FRAME_LENGTH - 2);

  localparam int HOLD_W = 56;

  localparam logic [7:0]  HDR_FIRST  = 8'hAA;
  localparam logic [7:0]  HDR_SECOND = 8'h55;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SEEN_AA = 2'd1,
    PH_FRAME   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] byte_time_ms;
  } byte_item_t;

  typedef struct packed {
    logic signed [15:0] roll_centi;
    logic signed [15:0] pitch_centi;
    logic signed [15:0] yaw_centi;
    logic [7:0]         altitude_tenths;
    logic [31:0]        packet_time_ms;
  } packet_item_t;

  // One byte of CRC-16, MSB first, no reflection.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC after the two header bytes, worked out at elaboration.
  localparam logic [15:0] CRC_AFTER_HDR = crc16_byte(crc16_byte(CRC_INIT, HDR_FIRST), HDR_SECOND);

endpackage

FILE: rtl/core/crc_framed_setpoint_packet_parser.sv
// Top level of the CRC-framed setpoint packet parser: header hunt, frame collection,
// CRC-16 check and result register, all in this one module.
// Depends on cfsp_pkg.
//
//   Channel  Direction  Handshake                  Payload
//   byte     in         byte_valid / byte_ready    byte_data   (byte_item_t)
//   packet   out        packet_valid / packet_ready packet_data (packet_item_t)
//
// An accepted byte is held in the input register and parsed there, and a frame whose CRC
// matches loads the result register, which raises packet_valid once the last frame byte
// has been parsed.
// One byte is taken every cycle; the only thing that slows the input is a result waiting
// in the result register, which stops the parse of the held byte until it is taken.
// Reset is synchronous and active high; it empties both registers and returns the parser
// to hunting for the first header byte.
module crc_framed_setpoint_packet_parser
  import cfsp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_ready,
  input  byte_item_t   byte_data,
  output logic         packet_valid,
  input  logic         packet_ready,
  output packet_item_t packet_data
);

  // Input register.
  logic       in_vld;
  byte_item_t in_item;

  // Parser state.
  phase_t             phase, phase_next;
  logic [IDX_W-1:0]   frame_index, frame_index_next;
  logic [15:0]        running_crc, running_crc_next;
  logic [HOLD_W-1:0]  payload_hold, payload_hold_next;
  logic [7:0]         trailer_high, trailer_high_next;

  logic go;
  logic frame_ok;

  // The held byte is parsed when the result register can take whatever it produces.
  assign go         = in_vld && (!packet_valid || packet_ready);
  assign byte_ready = !in_vld || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (byte_ready) begin
      in_vld <= byte_valid;
    end
    if (byte_valid && byte_ready) begin
      in_item <= byte_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      frame_index <= '0;
      running_crc <= CRC_INIT;
    end else begin
      phase       <= phase_next;
      frame_index <= frame_index_next;
      running_crc <= running_crc_next;
    end
    payload_hold <= payload_hold_next;
    trailer_high <= trailer_high_next;
  end

  // Next state. Once AA 55 has been seen the following bytes are taken as the frame
  // whatever their values; there is no resynchronisation inside a frame.
  always_comb begin
    phase_next        = phase;
    frame_index_next  = frame_index;
    running_crc_next  = running_crc;
    payload_hold_next = payload_hold;
    trailer_high_next = trailer_high;
    frame_ok          = 1'b0;
    if (go) begin
      case (phase)
        PH_SEEN_AA: begin
          if (in_item.data_byte == HDR_SECOND) begin
            phase_next       = PH_FRAME;
            frame_index_next = IDX_PAYLOAD_FIRST;
            running_crc_next = CRC_AFTER_HDR;
          end else if (in_item.data_byte != HDR_FIRST) begin
            // A repeated AA keeps the hunt armed; anything else breaks the header.
            phase_next       = PH_HUNT;
            frame_index_next = '0;
            running_crc_next = CRC_INIT;
          end
        end
        PH_FRAME: begin
          if (frame_index < IDX_TRAILER_HIGH) begin
            running_crc_next = crc16_byte(running_crc, in_item.data_byte);
            if (frame_index >= IDX_PAYLOAD_FIRST && frame_index <= IDX_PAYLOAD_LAST) begin
              payload_hold_next = {payload_hold[HOLD_W-9:0], in_item.data_byte};
            end
            frame_index_next = frame_index + IDX_W'(1);
          end else if (frame_index == IDX_TRAILER_HIGH) begin
            trailer_high_next = in_item.data_byte;
            frame_index_next  = frame_index + IDX_W'(1);
          end else begin
            // Last byte: compare the big-endian trailer and return to the hunt.
            frame_ok         = ({trailer_high, in_item.data_byte} == running_crc);
            phase_next       = PH_HUNT;
            frame_index_next = '0;
            running_crc_next = CRC_INIT;
          end
        end
        default: begin
          frame_index_next = '0;
          running_crc_next = CRC_INIT;
          phase_next       = (in_item.data_byte == HDR_FIRST) ? PH_SEEN_AA : PH_HUNT;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_valid <= 1'b0;
    end else if (go && frame_ok) begin
      packet_valid <= 1'b1;
    end else if (packet_ready) begin
      packet_valid <= 1'b0;
    end
    if (go && frame_ok) begin
      packet_data.roll_centi      <= payload_hold[55:40];
      packet_data.pitch_centi     <= payload_hold[39:24];
      packet_data.yaw_centi       <= payload_hold[23:8];
      packet_data.altitude_tenths <= payload_hold[7:0];
      packet_data.packet_time_ms  <= in_item.byte_time_ms;
    end
  end

`ifndef SYNTHESIS
  // A new result only ever follows the parse of a last frame byte.
  a_result_from_frame : assert property (@(posedge clk) disable iff (rst)
    $rose(packet_valid) |-> $past(go && phase == PH_FRAME))
    else $error("result appeared without a completed frame");

  // Outside a frame the index and CRC stay at their hunt values.
  a_hunt_clean : assert property (@(posedge clk) disable iff (rst)
    phase != PH_FRAME |-> (frame_index == '0 && running_crc == CRC_INIT))
    else $error("index or CRC not cleared while hunting");

  // Inside a frame the index stays within the frame.
  a_index_range : assert property (@(posedge clk) disable iff (rst)
    phase == PH_FRAME |-> (frame_index >= IDX_PAYLOAD_FIRST &&
                           frame_index <= IDX_W'(FRAME_LENGTH - 1)))
    else $error("frame index out of range");

  // A stalled input always has a byte held in the input register.
  a_stall_held : assert property (@(posedge clk) disable iff (rst)
    !byte_ready |-> (in_vld && packet_valid && !packet_ready))
    else $error("input stalled without cause");
`endif

endmodule
